>>> hdl/assert_macros.svh
// Assertion macros for the RTL files; fbc_ctrl is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an implication on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check a condition on the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/fbc_pkg.sv
// Shared types and constants for the frustum box culler.
package fbc_pkg;
    localparam int PLANE_REGS        = 6;
    localparam int DEF_NUM_PLANES    = 6;
    localparam int DEF_COORD_WIDTH   = 16;
    localparam int DEF_MATRIX_WIDTH  = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int PCOEF_W           = 16;
    localparam int IN_COORD_W        = 16;
    localparam int IN_COEF_W         = 32;
    localparam int CORNERS           = 8;
    localparam int S_TDATA_W         = 232;
    localparam logic [31:0] Q16_ONE  = 32'h0001_0000;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_WORLD = 2'd1,
        CMD_MODEL = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic       capture;   // latch box and clear the cull flag
        logic       load_row;  // write matrix row from input
        logic       q_step;    // accumulate one matrix term for the current plane
        logic       q_clear;
        logic       dot_step;  // evaluate one corner (model) or plane (world)
        logic       plane_clear;
        logic [2:0] plane;
        logic [1:0] row;       // matrix row for q_step
        logic [2:0] corner;
        logic       world;
        logic       finish;    // register the result
    } fbc_cmd_t;

    typedef struct packed {
        logic culled;
    } fbc_stat_t;
endpackage

>>> hdl/fbc_datapath.sv
// Datapath: plane registers, matrix, multiply-accumulate units and the cull flag.
module fbc_datapath #(
    parameter int NUM_PLANES   = fbc_pkg::DEF_NUM_PLANES,
    parameter int COORD_WIDTH  = fbc_pkg::DEF_COORD_WIDTH,
    parameter int MATRIX_WIDTH = fbc_pkg::DEF_MATRIX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [fbc_pkg::S_TDATA_W-1:0]       in_data,
    input  fbc_pkg::fbc_cmd_t                   cmd,
    output fbc_pkg::fbc_stat_t                  stat
);
    import fbc_pkg::*;

    // q terms: 16-bit plane * MATRIX_WIDTH matrix, four summed
    localparam int QW  = PCOEF_W + MATRIX_WIDTH + 2;
    localparam int CW  = COORD_WIDTH + 1;
    localparam int PW  = QW + CW;
    localparam int AW  = PW + 2;

    logic [CFG_DATA_W-1:0] plane_reg [PLANE_REGS];
    logic signed [MATRIX_WIDTH-1:0] mat_reg [16];
    logic signed [COORD_WIDTH-1:0] mn_reg [3];
    logic signed [COORD_WIDTH-1:0] mx_reg [3];
    logic signed [QW-1:0] q_reg [4];
    logic signed [AW-1:0] acc;
    logic inside_reg, cull_reg, culled_reg;
    logic [CFG_DATA_W-1:0] pl;
    logic signed [PCOEF_W-1:0] pc [4];
    logic signed [CW-1:0] v [4];
    logic signed [PW-1:0] prod [4];
    logic signed [QW-1:0] qterm [4];
    logic [1:0] r;

    always_comb begin
        pl = (32'(cmd.plane) < PLANE_REGS && 32'(cmd.plane) < NUM_PLANES)
            ? plane_reg[cmd.plane] : '0;
        for (int k = 0; k < 4; k++) pc[k] = pl[16*k +: 16];
        r = cmd.row;
        for (int j = 0; j < 4; j++)
            qterm[j] = QW'(pc[r]) * QW'(mat_reg[{r, 2'(j)}]);
        if (cmd.world) begin
            for (int k = 0; k < 3; k++)
                v[k] = pc[k][PCOEF_W-1] ? CW'(mn_reg[k]) : CW'(mx_reg[k]);
            v[3] = CW'(1);
            for (int k = 0; k < 4; k++) prod[k] = PW'(pc[k]) * PW'(v[k]);
        end else begin
            v[0] = cmd.corner[0] ? CW'(mx_reg[0]) : CW'(mn_reg[0]);
            v[1] = cmd.corner[1] ? CW'(mx_reg[1]) : CW'(mn_reg[1]);
            v[2] = cmd.corner[2] ? CW'(mx_reg[2]) : CW'(mn_reg[2]);
            v[3] = CW'(1);
            for (int k = 0; k < 4; k++) prod[k] = PW'(q_reg[k]) * PW'(v[k]);
        end
        acc = AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]) + AW'(prod[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_REGS; i++) plane_reg[i] <= '0;
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i % 5 == 0) ? MATRIX_WIDTH'(Q16_ONE) : '0;
            culled_reg <= 1'b0;
            cull_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end else begin
            if (cfg_we && 32'(cfg_index) < PLANE_REGS) plane_reg[cfg_index] <= cfg_data;
            if (cmd.load_row)
                for (int j = 0; j < 4; j++)
                    mat_reg[{in_data[3:2], 2'(j)}] <= in_data[4 + 32*j +: MATRIX_WIDTH];
            if (cmd.capture) begin
                for (int k = 0; k < 3; k++) begin
                    mn_reg[k] <= in_data[132 + 16*k +: COORD_WIDTH];
                    mx_reg[k] <= in_data[180 + 16*k +: COORD_WIDTH];
                end
                cull_reg <= 1'b0;
            end
            if (cmd.q_clear) for (int j = 0; j < 4; j++) q_reg[j] <= '0;
            else if (cmd.q_step) for (int j = 0; j < 4; j++) q_reg[j] <= q_reg[j] + qterm[j];
            if (cmd.plane_clear) inside_reg <= 1'b0;
            if (cmd.dot_step) begin
                if (cmd.world) begin
                    if (acc[AW-1]) cull_reg <= 1'b1;
                end else if (!acc[AW-1] && acc != '0) inside_reg <= 1'b1;
            end
            // close a model plane after its last corner
            if (cmd.dot_step && !cmd.world && cmd.corner == 3'(CORNERS-1)
                && !inside_reg && (acc[AW-1] || acc == '0)) cull_reg <= 1'b1;
            if (cmd.finish) culled_reg <= cull_reg;
        end
    end

    assign stat.culled = culled_reg;
endmodule

>>> hdl/fbc_ctrl.sv
// Controller: sequences matrix loads and folds, plane and corner tests and the output handshake.
module fbc_ctrl #(
    parameter int NUM_PLANES = fbc_pkg::DEF_NUM_PLANES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         in_cmd,
    output logic               m_tvalid,
    input  logic               m_tready,
    output fbc_pkg::fbc_cmd_t  cmd
);
    import fbc_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FOLD  = 5'b00010,
        ST_DOT   = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] plane_reg, plane_next;
    logic [2:0] cnt_reg, cnt_next;
    logic world_reg, world_next;
    logic acc_s;
    logic last_plane;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc_s = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign last_plane = (32'(plane_reg) == NUM_PLANES - 1);

    always_comb begin
        state_next = state_reg;
        plane_next = plane_reg;
        cnt_next   = cnt_reg;
        world_next = world_reg;
        cmd = '0;
        cmd.plane  = plane_reg;
        cmd.row    = cnt_reg[1:0];
        cmd.corner = cnt_reg;
        cmd.world  = world_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc_s) begin
                    plane_next = '0;
                    cnt_next   = '0;
                    case (cmd_t'(in_cmd))
                        CMD_LOAD: cmd.load_row = 1'b1;
                        CMD_WORLD: begin
                            cmd.capture = 1'b1;
                            world_next = 1'b1;
                            state_next = ST_DOT;
                        end
                        CMD_MODEL: begin
                            cmd.capture = 1'b1;
                            cmd.q_clear = 1'b1;
                            world_next = 1'b0;
                            state_next = ST_FOLD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FOLD: begin
                cmd.q_step = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3) begin
                    cnt_next = '0;
                    cmd.plane_clear = 1'b1;
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                cmd.dot_step = 1'b1;
                if (world_reg) begin
                    plane_next = plane_reg + 3'd1;
                    if (last_plane) state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(CORNERS-1)) begin
                        cnt_next = '0;
                        plane_next = plane_reg + 3'd1;
                        cmd.q_clear = 1'b1;
                        state_next = last_plane ? ST_FIN : ST_FOLD;
                    end
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            cnt_reg   <= '0;
            world_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            cnt_reg   <= cnt_next;
            world_reg <= world_next;
        end
    end

    `ASSERT_IMPL(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg))
    `ASSERT_IMPL(a_busy, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_fin_out, aclk, aresetn, state_reg == ST_FIN, m_tvalid)
    `ASSERT_IMPL(a_fold_model, aclk, aresetn, state_reg == ST_FOLD, !world_reg)
endmodule

>>> hdl/frustum_box_cull.sv
// Top level of the frustum box culler.
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: cmd,row_index,coef_a..d,min_xyz,max_xyz
//  m_      | out | m_tvalid/m_tready | m_tdata: culled
//  cfg     | in  | cfg_we            | cfg_index, cfg_data (plane 0..5)
// World test: the planes are tested against the box in turn. Model test: each plane is
// folded through the matrix row by row, then the eight box corners are tested. A load
// writes one matrix row. Reset loads the identity matrix and clears planes; one item
// is in work at a time.
module frustum_box_cull #(
    parameter int NUM_PLANES   = fbc_pkg::DEF_NUM_PLANES,
    parameter int COORD_WIDTH  = fbc_pkg::DEF_COORD_WIDTH,
    parameter int MATRIX_WIDTH = fbc_pkg::DEF_MATRIX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd[1:0], row_index[3:2], coef_a..coef_d[131:4], min_x,y,z[179:132],
    // max_x,y,z[227:180], zero pad
    input  logic [fbc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // culled[0], zero pad
    output logic [7:0]                       m_tdata,
    input  logic                             cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fbc_pkg::*;

    fbc_cmd_t  cmd;
    fbc_stat_t stat;

    fbc_ctrl #(.NUM_PLANES(NUM_PLANES)) u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .in_cmd(s_tdata[1:0]),
        .m_tvalid, .m_tready, .cmd
    );

    fbc_datapath #(
        .NUM_PLANES(NUM_PLANES), .COORD_WIDTH(COORD_WIDTH), .MATRIX_WIDTH(MATRIX_WIDTH)
    ) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .in_data(s_tdata), .cmd, .stat
    );

    assign m_tdata = {7'd0, stat.culled};
endmodule

>>> tb/fbc_checker.sv
// Checker for the frustum box culler: predicts culled flags and compares results.
`timescale 1ns / 100ps
module fbc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fbc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,
    input  logic                          cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            world_tests,
    output int                            model_tests,
    output int                            culled_seen
);
    import fbc_pkg::*;

    logic [63:0]        planes [PLANE_REGS];
    logic signed [31:0] xform [16];
    bit                 culled_q [$];

    function automatic logic signed [15:0] coef_of(int p, int k);
        return planes[p][16*k +: 16];
    endfunction

    function automatic bit world_culls(logic signed [15:0] mn [3],
                                       logic signed [15:0] mx [3]);
        logic signed [63:0] acc;
        logic signed [15:0] c;
        for (int p = 0; p < DEF_NUM_PLANES; p++) begin
            acc = coef_of(p, 3);
            for (int k = 0; k < 3; k++) begin
                c = coef_of(p, k);
                acc += 64'(c) * 64'(c < 0 ? mn[k] : mx[k]);
            end
            if (acc < 0) return 1;
        end
        return 0;
    endfunction

    function automatic bit model_culls(logic signed [15:0] mn [3],
                                       logic signed [15:0] mx [3]);
        logic signed [63:0]  q [4];
        logic signed [127:0] acc;
        logic signed [63:0]  v [3];
        bit                  hit;
        for (int p = 0; p < DEF_NUM_PLANES; p++) begin
            for (int j = 0; j < 4; j++) begin
                q[j] = 0;
                for (int k = 0; k < 4; k++)
                    q[j] += 64'(coef_of(p, k)) * 64'(xform[k*4+j]);
            end
            hit = 0;
            for (int n = 0; n < CORNERS; n++) begin
                v[0] = n[0] ? mx[0] : mn[0];
                v[1] = n[1] ? mx[1] : mn[1];
                v[2] = n[2] ? mx[2] : mn[2];
                acc = 128'(q[3]);
                for (int j = 0; j < 3; j++) acc += 128'(v[j]) * 128'(q[j]);
                if (acc > 0) hit = 1;
            end
            if (!hit) return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        logic [1:0]         cmd;
        logic [1:0]         row;
        logic signed [15:0] mn [3];
        logic signed [15:0] mx [3];
        bit                 exp_c;
        if (!aresetn) begin
            foreach (planes[i]) planes[i] <= '0;
            for (int i = 0; i < 16; i++) xform[i] <= (i % 5 == 0) ? Q16_ONE : '0;
            culled_q.delete();
            fail_count <= 0;
            world_tests <= 0;
            model_tests <= 0;
            culled_seen <= 0;
        end else begin
            if (cfg_we && cfg_index < PLANE_REGS) planes[cfg_index] <= cfg_data;
            if (s_tvalid && s_tready) begin
                cmd = s_tdata[1:0];
                row = s_tdata[3:2];
                for (int k = 0; k < 3; k++) begin
                    mn[k] = s_tdata[132 + 16*k +: 16];
                    mx[k] = s_tdata[180 + 16*k +: 16];
                end
                if (cmd == CMD_LOAD) begin
                    for (int k = 0; k < 4; k++) xform[row*4+k] <= s_tdata[4 + 32*k +: 32];
                end else if (cmd == CMD_WORLD) begin
                    culled_q.push_back(world_culls(mn, mx));
                    world_tests <= world_tests + 1;
                end else if (cmd == CMD_MODEL) begin
                    culled_q.push_back(model_culls(mn, mx));
                    model_tests <= model_tests + 1;
                end
            end
            if (m_tvalid && m_tready) begin
                if (culled_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual culled=%0b",
                             $time, m_tdata[0]);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_c = culled_q.pop_front();
                    if (m_tdata !== {7'd0, exp_c}) begin
                        $display("%0t: culled expected %0b, actual %0h",
                                 $time, exp_c, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                    if (exp_c) culled_seen <= culled_seen + 1;
                end
            end
        end
    end

    assign pending = culled_q.size();
endmodule

>>> tb/tb_top.sv
// Testbench top for the frustum box culler: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_top;
    import fbc_pkg::*;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [7:0]            m_tdata;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int  fail_count, pending, world_tests, model_tests, culled_seen;
    bit  hold_off = 0;

    always #10 aclk = ~aclk;

    frustum_box_cull u_top (.*);

    fbc_checker u_chk (.*);

    // Random receiver stalls, plus a long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
                do @(posedge aclk); while (!(m_tvalid && m_tready));
                #1;
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [1:0] row, logic [127:0] coefs,
                             logic [47:0] mins, logic [47:0] maxs, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        repeat (gap) @(negedge aclk);
        s_tdata  <= {4'd0, maxs, mins, coefs, row, cmd};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic write_plane(int idx, logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    function automatic logic [47:0] rand_box3(int mode);
        logic [47:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = mode == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 400)) - 200);
        return r;
    endfunction

    function automatic logic [127:0] rand_row(int mode);
        logic [127:0] r;
        for (int k = 0; k < 4; k++)
            r[32*k +: 32] = mode == 0 ? $urandom
                          : 32'($signed($urandom_range(0, 262144)) - 131072);
        return r;
    endfunction

    function automatic logic [63:0] rand_plane(int mode);
        logic [63:0] r;
        for (int k = 0; k < 4; k++)
            r[16*k +: 16] = mode == 0 ? 16'($urandom)
                          : 16'($signed($urandom_range(0, 1024)) - 512);
        return r;
    endfunction

    initial begin
        logic [1:0] cmd;
        int mode;
        repeat (2) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // Directed: all-zero planes, reset identity, inverted and extreme boxes.
        send_item(CMD_WORLD, 0, '0, {3{16'h8000}}, {3{16'h7fff}}, 0);
        send_item(CMD_MODEL, 0, '0, {3{16'h8000}}, {3{16'h7fff}}, 0);
        send_item(CMD_NONE, 3, '1, '1, '1, 0);
        drain();
        for (int p = 0; p < 8; p++)
            write_plane(p, p < 3 ? {16'h7fff, 16'h8000, 16'h0100, 16'hff00}
                                 : {16'h0100, 16'h0000, 16'h0000, 16'h0100});
        send_item(CMD_WORLD, 0, '0, {3{16'h7fff}}, {3{16'h8000}}, 0);
        send_item(CMD_MODEL, 0, '0, {3{16'h7fff}}, {3{16'h8000}}, 0);
        send_item(CMD_LOAD, 0, {4{32'h8000_0000}}, '0, '0, 0);
        send_item(CMD_LOAD, 3, {4{32'h7fff_ffff}}, '0, '0, 0);
        send_item(CMD_LOAD, 1, '1, '0, '0, 0);
        send_item(CMD_LOAD, 2, '0, '0, '0, 0);
        send_item(CMD_MODEL, 0, '0, {3{16'h8000}}, {3{16'h7fff}}, 0);
        send_item(CMD_MODEL, 0, '0, '1, '0, 0);
        send_item(CMD_WORLD, 0, '0, 48'h0, 48'h0, 0);
        drain();
        // Random phases with fresh plane settings between them.
        for (int ph = 0; ph < 15; ph++) begin
            mode = ph % 3;
            for (int p = 0; p < 7; p++)
                write_plane(p, ph == 14 ? '1 : (ph == 13 ? '0 : rand_plane(mode)));
            if (ph == 5) hold_off = 1;
            for (int i = 0; i < 100; i++) begin
                cmd = $urandom_range(0, 9) < 1 ? 2'($urandom_range(0, 3))
                    : ($urandom_range(0, 4) == 0 ? CMD_LOAD
                    : ($urandom_range(0, 1) ? CMD_WORLD : CMD_MODEL));
                send_item(cmd, 2'($urandom), rand_row(mode), rand_box3(mode),
                          rand_box3(mode), ph == 5);
            end
            drain();
        end
        $display("covered %0d world and %0d model tests, %0d culled, 15 plane settings",
                 world_tests, model_tests, culled_seen);
        if (fail_count == 0) begin
            $display("frustum_box_cull: match");
        end else begin
            $display("frustum_box_cull: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("frustum_box_cull: mismatch");
        $finish;
    end
endmodule
